>>> rtl/ilmg_pkg.sv
// ----------------------------------------------------------------------------
// ilmg_pkg
// Shared types and constants for the line mirror / grayscale block.
// ----------------------------------------------------------------------------
package ilmg_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int COMPONENT_BITS = 16;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS      = COL_BITS + 1;
    localparam int WIDTH_BITS     = COL_BITS + 1;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = WIDTH_BITS;

    // floor(x / 3) by reciprocal multiply, exact for x below 2**GRAY_SHIFT
    localparam int SUM_BITS    = COMPONENT_BITS + 2;
    localparam int GRAY_SHIFT  = COMPONENT_BITS + 3;
    localparam int RECIP_BITS  = GRAY_SHIFT - 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] GRAY_RECIP = RECIP_BITS'((2 ** GRAY_SHIFT) / 3 + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIRROR_ENABLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAY_ENABLE   = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [COMPONENT_BITS-1:0] red_in;
        logic [COMPONENT_BITS-1:0] green_in;
        logic [COMPONENT_BITS-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red_out;
        logic [COMPONENT_BITS-1:0] green_out;
        logic [COMPONENT_BITS-1:0] blue_out;
        logic                      line_end;
    } t_out_item;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
    } t_pixel;

endpackage

>>> rtl/image_line_mirror_grayscale.sv
// ----------------------------------------------------------------------------
// image_line_mirror_grayscale
// Horizontal line mirror and average grayscale for a raster RGB stream.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid / i_in_item and leave on o_out_valid /
// o_out_item; the receiver of each channel holds off with its stall line.
// A pixel request with mirroring off yields one pixel at once. With mirroring
// on, each line goes into one of two ping-pong banks of a single 8192 x 48
// line memory while the previous line is read back in reverse, one pixel per
// request; drain requests empty the last line. line_end marks the last pixel
// of each emitted line. Gray replaces all components by floor((r+g+b)/3).
// Each accepted request loads the middle stage and the memory read; the
// output register is loaded from the middle stage after the gray multiply
// once the output is free to take it.
// Throughput: one request per cycle while the output does not stall, set by
// the single write and single read port of the line memory; a line-end write
// followed at once by a read of the same entry is forwarded around the memory.
// When the output is stalled, the middle stage holds and then the input
// stalls; the output register parts the two sides.
// Reset clears the counters, bank select and pending flag and loads the
// registers with line_width 4096, mirror and gray off. The line memory is not
// cleared; it is read on each accepted request, used only by mirrored results.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
module image_line_mirror_grayscale
    import ilmg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item
);

    // configuration
    logic [WIDTH_BITS-1:0] r_line_width;
    logic                  r_mirror;
    logic                  r_gray;

    // stream state
    logic [COL_BITS-1:0] r_wc, n_wc;
    logic [COL_BITS-1:0] r_rc, n_rc;
    logic                r_wb, n_wb;
    logic                r_pending, n_pending;

    // middle stage
    logic                 r_s1_valid;
    logic                 r_s1_emit;
    logic                 r_s1_src_mem;
    logic                 r_s1_end;
    logic                 r_s1_wr;
    logic [ADDR_BITS-1:0] r_s1_waddr;
    logic                 r_s1_gray;
    t_pixel               r_s1_pix;
    t_pixel               r_rd_data;
    logic                 r_fwd_hit;
    t_pixel               r_fwd_pix;

    // output stage
    logic      r_out_valid;
    t_out_item r_out_item;

    t_pixel r_mem [2*MAX_WIDTH];

    logic                  accept;
    logic                  s1_fire;
    logic [WIDTH_BITS-1:0] w_eff;
    logic [WIDTH_BITS-1:0] wc_inc;
    logic [WIDTH_BITS-1:0] rc_inc;
    logic                  end_w;
    logic                  end_r;
    logic [COL_BITS-1:0]   rd_col;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  n_emit;
    logic                  n_src_mem;
    logic                  n_end;
    logic                  n_wr;
    logic [SUM_BITS-1:0]   gray_sum;
    logic [PROD_BITS-1:0]  gray_prod;
    logic [COMPONENT_BITS-1:0] gray_avg;
    t_pixel                s1_pix;
    t_pixel                emit_pix;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= WIDTH_BITS'(MAX_WIDTH);
            r_mirror     <= 1'b0;
            r_gray       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH:    r_line_width <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_MIRROR_ENABLE: r_mirror     <= i_cfg_data[0];
                CFG_GRAY_ENABLE:   r_gray       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_line_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (r_line_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_line_width;
        end
    end

    assign wc_inc = {1'b0, r_wc} + WIDTH_BITS'(1);
    assign rc_inc = {1'b0, r_rc} + WIDTH_BITS'(1);
    assign end_w  = wc_inc >= w_eff;
    assign end_r  = rc_inc >= w_eff;
    assign rd_col = ({1'b0, r_rc} < w_eff)
                  ? COL_BITS'(w_eff - WIDTH_BITS'(1) - {1'b0, r_rc}) : '0;
    assign rd_addr = {~r_wb, rd_col};

    always_comb begin
        n_wc      = r_wc;
        n_rc      = r_rc;
        n_wb      = r_wb;
        n_pending = r_pending;
        n_emit    = 1'b0;
        n_src_mem = 1'b0;
        n_end     = 1'b0;
        n_wr      = 1'b0;
        priority if (i_in_item.action == ACT_DRAIN) begin
            if (r_pending) begin
                n_emit    = 1'b1;
                n_src_mem = 1'b1;
                n_end     = end_r;
                n_rc      = end_r ? '0 : COL_BITS'(rc_inc);
                n_pending = !end_r;
            end
        end else if (!r_mirror) begin
            n_emit = 1'b1;
            n_end  = end_w;
            n_wc   = end_w ? '0 : COL_BITS'(wc_inc);
        end else begin
            if (r_pending) begin
                n_emit    = 1'b1;
                n_src_mem = 1'b1;
                n_end     = end_r;
                n_rc      = end_r ? '0 : COL_BITS'(rc_inc);
                n_pending = !end_r;
            end
            n_wr = 1'b1;
            if (end_w) begin
                n_wc      = '0;
                n_wb      = ~r_wb;
                n_pending = 1'b1;
                n_rc      = '0;
            end else begin
                n_wc = COL_BITS'(wc_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc      <= '0;
            r_rc      <= '0;
            r_wb      <= 1'b0;
            r_pending <= 1'b0;
        end else if (accept) begin
            r_wc      <= n_wc;
            r_rc      <= n_rc;
            r_wb      <= n_wb;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // write of the previous request lands at the same edge as this read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit    <= n_emit;
            r_s1_src_mem <= n_src_mem;
            r_s1_end     <= n_end;
            r_s1_wr      <= n_wr;
            r_s1_waddr   <= {r_wb, r_wc};
            r_s1_gray    <= r_gray;
            r_s1_pix     <= '{red:   i_in_item.red_in,
                              green: i_in_item.green_in,
                              blue:  i_in_item.blue_in};
            r_fwd_hit    <= r_s1_valid && r_s1_wr && (r_s1_waddr == rd_addr);
            r_fwd_pix    <= s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_wr) begin
            r_mem[r_s1_waddr] <= s1_pix;
        end
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign gray_sum  = SUM_BITS'(r_s1_pix.red) + SUM_BITS'(r_s1_pix.green)
                     + SUM_BITS'(r_s1_pix.blue);
    assign gray_prod = PROD_BITS'(gray_sum) * PROD_BITS'(GRAY_RECIP);
    assign gray_avg  = gray_prod[GRAY_SHIFT +: COMPONENT_BITS];

    assign s1_pix   = r_s1_gray ? t_pixel'{red: gray_avg, green: gray_avg, blue: gray_avg}
                                : r_s1_pix;
    assign emit_pix = !r_s1_src_mem ? s1_pix
                    : (r_fwd_hit ? r_fwd_pix : r_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_item <= '{red_out:   emit_pix.red,
                            green_out: emit_pix.green,
                            blue_out:  emit_pix.blue,
                            line_end:  r_s1_end};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // input only stalls behind a held middle stage
    a_stall_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty middle stage");

    // a memory-sourced result is always emitted
    a_mem_src_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_src_mem) |-> r_s1_emit)
        else $error("memory read without a result");

    // a drain with nothing buffered yields no result
    a_empty_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_item.action == ACT_DRAIN) && !r_pending)
        |=> (r_s1_valid && !r_s1_emit))
        else $error("drain on empty line produced a result");

    // the bank flips only when a completed line becomes pending
    a_flip_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_wb != $past(r_wb))) |-> (r_pending && (r_rc == '0)))
        else $error("bank flip without pending line");

endmodule
